// ----- sv/csd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package csd_pkg;

    localparam int POS_W   = 12;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W    = 4;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_MOVE    = 2'd1,
        OP_RELEASE = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IGNORED   = 3'd0,
        ST_STARTED   = 3'd1,
        ST_ACCEPTED  = 3'd2,
        ST_SKIPPED   = 3'd3,
        ST_CLOSED    = 3'd4,
        ST_DISCARDED = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_STEP        = 3'd0,
        CFG_MIN_POINTS      = 3'd1,
        CFG_MIN_EXTENT      = 3'd2,
        CFG_MAX_ASPECT      = 3'd3,
        CFG_CLOSURE_DIVISOR = 3'd4
    } cfg_index_t;

    localparam logic [7:0]  RST_MIN_STEP        = 8'd10;
    localparam logic [9:0]  RST_MIN_POINTS      = 10'd10;
    localparam logic [11:0] RST_MIN_EXTENT      = 12'd10;
    localparam logic [3:0]  RST_MAX_ASPECT      = 4'd2;
    localparam logic [7:0]  RST_CLOSURE_DIVISOR = 8'd10;

    // sequencer control word fields
    typedef enum logic {
        SEQ_NEXT,
        SEQ_SKIP_IDLE
    } seq_t;

    typedef enum logic [3:0] {
        OPS_HOLD,
        OPS_DX_LAST,
        OPS_DY_LAST,
        OPS_DX_FIRST,
        OPS_DY_FIRST,
        OPS_STEP,
        OPS_REACH,
        OPS_SQUARE,
        OPS_ASPECT
    } ops_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_t;

    typedef enum logic {
        CHK_NONE,
        CHK_EXTENT
    } chk_t;

    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_IGNORE,
        FIN_PRESS,
        FIN_MOVE,
        FIN_RELEASE
    } fin_t;

    typedef struct packed {
        seq_t            seq;
        logic [PC_W-1:0] target;
        ops_t            ops;
        acc_t            acc;
        logic            save;
        chk_t            chk;
        fin_t            fin;
    } ctrl_word_t;

    localparam ctrl_word_t CTRL_NOP = '{
        seq: SEQ_NEXT, target: '0, ops: OPS_HOLD, acc: ACC_HOLD,
        save: 1'b0, chk: CHK_NONE, fin: FIN_NONE
    };

    localparam logic [PC_W-1:0] ADDR_PRESS   = 4'd0;
    localparam logic [PC_W-1:0] ADDR_IGNORE  = 4'd1;
    localparam logic [PC_W-1:0] ADDR_MOVE    = 4'd2;
    localparam logic [PC_W-1:0] ADDR_RELEASE = 4'd7;

    function automatic logic [PC_W-1:0] csd_entry(input logic [1:0] op);
        logic [PC_W-1:0] addr;
        case (op)
            OP_PRESS:   addr = ADDR_PRESS;
            OP_MOVE:    addr = ADDR_MOVE;
            OP_RELEASE: addr = ADDR_RELEASE;
            default:    addr = ADDR_IGNORE;
        endcase
        return addr;
    endfunction

    // microprogram; operands chosen by a step are registered in a_reg and b_reg, and their product then in prod_reg
    function automatic ctrl_word_t csd_rom(input logic [PC_W-1:0] addr);
        ctrl_word_t w;
        w = CTRL_NOP;
        case (addr)
            4'd0:  w.fin = FIN_PRESS;
            4'd1:  w.fin = FIN_IGNORE;
            // move: dx^2 + dy^2 against min_step^2
            4'd2:
            begin
                w.seq    = SEQ_SKIP_IDLE;
                w.target = ADDR_IGNORE;
                w.ops    = OPS_DX_LAST;
            end
            4'd3:  w.ops = OPS_DY_LAST;
            4'd4:
            begin
                w.ops = OPS_STEP;
                w.acc = ACC_LOAD;
            end
            4'd5:  w.acc = ACC_ADD;
            4'd6:  w.fin = FIN_MOVE;
            // release: extents, reach^2 against gap^2, aspect product
            4'd7:
            begin
                w.seq    = SEQ_SKIP_IDLE;
                w.target = ADDR_IGNORE;
                w.chk    = CHK_EXTENT;
            end
            4'd8:  w.ops = OPS_REACH;
            4'd9:  w.ops = OPS_DX_FIRST;
            4'd10: w.ops = OPS_SQUARE;
            4'd11:
            begin
                w.ops = OPS_DY_FIRST;
                w.acc = ACC_LOAD;
            end
            4'd12:
            begin
                w.ops  = OPS_ASPECT;
                w.save = 1'b1;
            end
            4'd13: w.acc = ACC_ADD;
            4'd14: w.fin = FIN_RELEASE;
            default: w.fin = FIN_IGNORE;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- sv/csd_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module csd_seq
    import csd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] opcode,
    input  wire logic       active,
    input  wire logic       out_free,
    output ctrl_word_t      ctrl,
    output logic            busy
);

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_word_t      word;
    logic            step_go;

    always_comb
    begin
        word = csd_rom(pc_reg);
        // a finishing step waits until the result register is free
        step_go = busy_reg && ((word.fin == FIN_NONE) || out_free);
        ctrl = step_go ? word : CTRL_NOP;
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = csd_entry(opcode);
        end
        else if (step_go)
        begin
            if (word.fin != FIN_NONE)
            begin
                busy_next = 1'b0;
            end
            else if ((word.seq == SEQ_SKIP_IDLE) && !active)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// ----- sv/closed_stroke_detector.sv -----
// sequencing: each accepted press, move or release runs its microprogram, and the result is
// registered at the finishing step, which waits while the result register is still occupied
// one transaction at a time: a new one is taken only after the last one finishes, paced by the
// microprogram length through one shared 20x20 multiplier at the default coordinate width
// reset: asynchronous active low; no stroke, stroke state zero, registers at their defaults
`timescale 1ns / 1ps
`default_nettype none

module closed_stroke_detector
    import csd_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           opcode,
    input  wire logic [POS_W-1:0]     pos_x,
    input  wire logic [POS_W-1:0]     pos_y,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                status,
    output logic [POS_W-1:0]          point_x,
    output logic [POS_W-1:0]          point_y,
    output logic [COUNT_W-1:0]        point_count
);

    localparam int CW = COORD_BITS;
    localparam int EW = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;
    localparam int MW = COORD_BITS + 8;
    localparam int PW = 2 * MW;
    localparam int AW = 2 * COORD_BITS + 1;

    // configuration
    logic [7:0]  min_step_reg;
    logic [9:0]  min_points_reg;
    logic [11:0] min_extent_reg;
    logic [3:0]  max_aspect_reg;
    logic [7:0]  closure_div_reg;

    // stroke state
    logic               active_reg, active_next;
    logic [CW-1:0]      first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic [CW-1:0]      last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic [CW-1:0]      min_x_reg, min_x_next, min_y_reg, min_y_next;
    logic [CW-1:0]      max_x_reg, max_x_next, max_y_reg, max_y_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // datapath
    logic [CW-1:0] in_x_reg, in_y_reg;
    logic [MW-1:0] a_reg, a_next, b_reg, b_next;
    logic [PW-1:0] prod_reg, keep_reg, keep_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic          flag_reg, flag_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         status_reg, status_next;
    logic [POS_W-1:0]   px_reg, px_next, py_reg, py_next;
    logic [COUNT_W-1:0] pc_reg, pc_next;

    ctrl_word_t ctrl;
    logic       busy;
    logic       in_fire;
    logic       out_free;

    logic [CW-1:0]      dx_last, dy_last, dx_first, dy_first, ext_x, ext_y;
    logic [COUNT_W-1:0] count_inc;
    logic               step_ok, closed;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = !busy;
    assign out_free = !out_valid_reg || out_ready;

    csd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .opcode   (opcode),
        .active   (active_reg),
        .out_free (out_free),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    always_comb
    begin
        dx_last  = (in_x_reg >= last_x_reg) ? in_x_reg - last_x_reg : last_x_reg - in_x_reg;
        dy_last  = (in_y_reg >= last_y_reg) ? in_y_reg - last_y_reg : last_y_reg - in_y_reg;
        dx_first = (first_x_reg >= last_x_reg) ? first_x_reg - last_x_reg
                                               : last_x_reg - first_x_reg;
        dy_first = (first_y_reg >= last_y_reg) ? first_y_reg - last_y_reg
                                               : last_y_reg - first_y_reg;
        ext_x    = max_x_reg - min_x_reg;
        ext_y    = max_y_reg - min_y_reg;
        count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        step_ok  = PW'(acc_reg) > prod_reg;
        closed   = flag_reg && (keep_reg > PW'(acc_reg)) && (prod_reg > PW'(hi_reg));
    end

    // operand select, accumulator, product keep register and extent latch
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        keep_next = keep_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        flag_next = flag_reg;

        case (ctrl.ops)
            OPS_DX_LAST:
            begin
                a_next = MW'(dx_last);
                b_next = MW'(dx_last);
            end
            OPS_DY_LAST:
            begin
                a_next = MW'(dy_last);
                b_next = MW'(dy_last);
            end
            OPS_DX_FIRST:
            begin
                a_next = MW'(dx_first);
                b_next = MW'(dx_first);
            end
            OPS_DY_FIRST:
            begin
                a_next = MW'(dy_first);
                b_next = MW'(dy_first);
            end
            OPS_STEP:
            begin
                a_next = MW'(min_step_reg);
                b_next = MW'(min_step_reg);
            end
            OPS_REACH:
            begin
                a_next = MW'(lo_reg);
                b_next = MW'(closure_div_reg);
            end
            OPS_SQUARE:
            begin
                a_next = prod_reg[MW-1:0];
                b_next = prod_reg[MW-1:0];
            end
            OPS_ASPECT:
            begin
                a_next = MW'(lo_reg);
                b_next = MW'(max_aspect_reg);
            end
            default:
            begin
                a_next = a_reg;
                b_next = b_reg;
            end
        endcase

        case (ctrl.acc)
            ACC_LOAD: acc_next = prod_reg[AW-1:0];
            ACC_ADD:  acc_next = acc_reg + prod_reg[AW-1:0];
            default:  acc_next = acc_reg;
        endcase

        if (ctrl.save)
        begin
            keep_next = prod_reg;
        end

        if (ctrl.chk == CHK_EXTENT)
        begin
            lo_next   = (ext_x < ext_y) ? ext_x : ext_y;
            hi_next   = (ext_x < ext_y) ? ext_y : ext_x;
            flag_next = (count_reg > COUNT_W'(min_points_reg))
                     && (EW'(ext_x) > EW'(min_extent_reg))
                     && (EW'(ext_y) > EW'(min_extent_reg));
        end
    end

    // stroke state update and result at the finishing step
    always_comb
    begin
        active_next  = active_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        min_x_next   = min_x_reg;
        min_y_next   = min_y_reg;
        max_x_next   = max_x_reg;
        max_y_next   = max_y_reg;
        count_next   = count_reg;

        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pc_next        = pc_reg;

        if (ctrl.fin != FIN_NONE)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_IGNORED;
            px_next        = '0;
            py_next        = '0;
            pc_next        = '0;
        end

        case (ctrl.fin)
            FIN_PRESS:
            begin
                active_next  = 1'b1;
                first_x_next = in_x_reg;
                first_y_next = in_y_reg;
                last_x_next  = in_x_reg;
                last_y_next  = in_y_reg;
                min_x_next   = in_x_reg;
                min_y_next   = in_y_reg;
                max_x_next   = in_x_reg;
                max_y_next   = in_y_reg;
                count_next   = COUNT_W'(1);
                status_next  = ST_STARTED;
                px_next      = POS_W'(EW'(in_x_reg));
                py_next      = POS_W'(EW'(in_y_reg));
                pc_next      = COUNT_W'(1);
            end
            FIN_MOVE:
            begin
                if (step_ok)
                begin
                    last_x_next = in_x_reg;
                    last_y_next = in_y_reg;
                    if (in_x_reg < min_x_reg) min_x_next = in_x_reg;
                    if (in_y_reg < min_y_reg) min_y_next = in_y_reg;
                    if (in_x_reg > max_x_reg) max_x_next = in_x_reg;
                    if (in_y_reg > max_y_reg) max_y_next = in_y_reg;
                    count_next  = count_inc;
                    status_next = ST_ACCEPTED;
                    px_next     = POS_W'(EW'(in_x_reg));
                    py_next     = POS_W'(EW'(in_y_reg));
                    pc_next     = count_inc;
                end
                else
                begin
                    status_next = ST_SKIPPED;
                    pc_next     = count_reg;
                end
            end
            FIN_RELEASE:
            begin
                if (closed)
                begin
                    count_next  = count_inc;
                    status_next = ST_CLOSED;
                    px_next     = POS_W'(EW'(first_x_reg));
                    py_next     = POS_W'(EW'(first_y_reg));
                    pc_next     = count_inc;
                end
                else
                begin
                    count_next  = '0;
                    status_next = ST_DISCARDED;
                end
                active_next = 1'b0;
                min_x_next  = '0;
                min_y_next  = '0;
                max_x_next  = '0;
                max_y_next  = '0;
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_step_reg    <= RST_MIN_STEP;
            min_points_reg  <= RST_MIN_POINTS;
            min_extent_reg  <= RST_MIN_EXTENT;
            max_aspect_reg  <= RST_MAX_ASPECT;
            closure_div_reg <= RST_CLOSURE_DIVISOR;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MIN_STEP:        min_step_reg    <= cfg_data[7:0];
                CFG_MIN_POINTS:      min_points_reg  <= cfg_data[9:0];
                CFG_MIN_EXTENT:      min_extent_reg  <= cfg_data[11:0];
                CFG_MAX_ASPECT:      max_aspect_reg  <= cfg_data[3:0];
                CFG_CLOSURE_DIVISOR: closure_div_reg <= cfg_data[7:0];
                default:             min_step_reg    <= min_step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            min_x_reg     <= '0;
            min_y_reg     <= '0;
            max_x_reg     <= '0;
            max_y_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            first_x_reg   <= first_x_next;
            first_y_reg   <= first_y_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            min_x_reg     <= min_x_next;
            min_y_reg     <= min_y_next;
            max_x_reg     <= max_x_next;
            max_y_reg     <= max_y_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_x_reg <= CW'(EW'(pos_x));
            in_y_reg <= CW'(EW'(pos_y));
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        prod_reg   <= PW'(a_reg * b_reg);
        keep_reg   <= keep_next;
        acc_reg    <= acc_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        flag_reg   <= flag_next;
        status_reg <= status_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        pc_reg     <= pc_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign point_count = pc_reg;

`ifndef SYNTHESIS
    // one transaction in flight: an accepted item holds off the next
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in progress");

    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_IGNORED) |-> (point_x == '0) && (point_y == '0)
            && (point_count == '0))
        else $error("ignored event with nonzero result fields");

    a_skip_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_SKIPPED || status == ST_DISCARDED)
            |-> (point_x == '0) && (point_y == '0))
        else $error("skipped or discarded event carries a point");

    a_result_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(busy))
        else $error("result appeared without a running microprogram");
`endif

endmodule

`default_nettype wire
